// ===== rtl/core/cc_pkg.sv =====
// shared types, constants and round functions for the chacha20 keystream block
// no dependencies
`default_nettype none
package cc_pkg;

  localparam int unsigned WordW   = 32;
  localparam int unsigned CfgW    = 64;
  localparam int unsigned NumRnd  = 20;
  localparam int unsigned RndW    = $clog2(NumRnd);

  localparam logic [31:0] SIGMA0 = 32'h6170_7865;
  localparam logic [31:0] SIGMA1 = 32'h3320_646e;
  localparam logic [31:0] SIGMA2 = 32'h7962_2d32;
  localparam logic [31:0] SIGMA3 = 32'h6b20_6574;

  // configuration register indexes
  localparam logic [2:0] REG_KEY_0_1   = 3'd0;
  localparam logic [2:0] REG_KEY_2_3   = 3'd1;
  localparam logic [2:0] REG_KEY_4_5   = 3'd2;
  localparam logic [2:0] REG_KEY_6_7   = 3'd3;
  localparam logic [2:0] REG_NONCE_0_1 = 3'd4;
  localparam logic [2:0] REG_NONCE_2   = 3'd5;

  typedef logic [15:0][WordW-1:0] state_t;
  typedef logic [7:0][WordW-1:0]  key_t;
  typedef logic [2:0][WordW-1:0]  nonce_t;

  // head of the counter queue as seen by the round engine
  typedef struct packed {
    logic             valid;
    logic [WordW-1:0] ctr;
  } cc_req_t;

  typedef struct packed {
    logic [WordW-1:0] a;
    logic [WordW-1:0] b;
    logic [WordW-1:0] c;
    logic [WordW-1:0] d;
  } qr_t;

  function automatic logic [WordW-1:0] rotl(input logic [WordW-1:0] v, input int unsigned n);
    rotl = (v << n) | (v >> (WordW - n));
  endfunction

  function automatic qr_t quarter(input qr_t q);
    qr_t r;
    r = q;
    r.a = r.a + r.b; r.d = rotl(r.d ^ r.a, 16);
    r.c = r.c + r.d; r.b = rotl(r.b ^ r.c, 12);
    r.a = r.a + r.b; r.d = rotl(r.d ^ r.a, 8);
    r.c = r.c + r.d; r.b = rotl(r.b ^ r.c, 7);
    quarter = r;
  endfunction

  // one column round (diag low) or one diagonal round (diag high)
  function automatic state_t do_round(input state_t s, input logic diag);
    state_t     r;
    qr_t        q;
    logic [1:0] ib;
    logic [1:0] ic;
    logic [1:0] id;
    r = s;
    for (int i = 0; i < 4; i++) begin
      ib = 2'(i + (diag ? 1 : 0));
      ic = 2'(i + (diag ? 2 : 0));
      id = 2'(i + (diag ? 3 : 0));
      q.a = s[i];
      q.b = s[{2'd1, ib}];
      q.c = s[{2'd2, ic}];
      q.d = s[{2'd3, id}];
      q = quarter(q);
      r[i]           = q.a;
      r[{2'd1, ib}]  = q.b;
      r[{2'd2, ic}]  = q.c;
      r[{2'd3, id}]  = q.d;
    end
    do_round = r;
  endfunction

  function automatic state_t init_state(input key_t key, input nonce_t nonce,
                                        input logic [WordW-1:0] ctr);
    state_t s;
    s[0] = SIGMA0;
    s[1] = SIGMA1;
    s[2] = SIGMA2;
    s[3] = SIGMA3;
    for (int i = 0; i < 8; i++) begin
      s[4 + i] = key[i];
    end
    s[12] = ctr;
    for (int i = 0; i < 3; i++) begin
      s[13 + i] = nonce[i];
    end
    init_state = s;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/cc_front.sv =====
// front end: takes block counters and holds them in a two-entry queue
// depends on cc_pkg
`default_nettype none
module cc_front
  import cc_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [WordW-1:0] block_counter,
  output cc_req_t               head,
  input  wire logic             pop
);

  logic [1:0][WordW-1:0] ent;
  logic                  wr_ptr;
  logic                  rd_ptr;
  logic [1:0]            count;
  logic                  push;
  logic                  do_pop;

  assign in_ready   = (count != 2'd2);
  assign push       = in_valid && in_ready;
  assign do_pop     = pop && (count != 2'd0);
  assign head.valid = (count != 2'd0);
  assign head.ctr   = ent[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      ent[wr_ptr] <= block_counter;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !do_pop) begin
        count <= count + 2'd1;
      end else if (!push && do_pop) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/cc_rounds.sv =====
// round engine: one column or diagonal round per cycle, then the feed-forward add
// depends on cc_pkg
`default_nettype none
module cc_rounds
  import cc_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire key_t    key,
  input  wire nonce_t  nonce,
  input  wire cc_req_t head,
  output logic         pop,
  output logic         res_valid,
  output state_t       res,
  input  wire logic    res_take
);

  state_t           work;
  logic [WordW-1:0] ctr;
  logic [RndW-1:0]  rnd;
  logic             busy;
  logic             done;
  logic             start;
  state_t           orig;

  assign orig      = init_state(key, nonce, ctr);
  // engine is free once its result has gone to the output buffer
  assign start     = head.valid && !busy && (!done || res_take);
  assign pop       = start;
  assign res_valid = done;

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      res[i] = work[i] + orig[i];
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ctr  <= head.ctr;
      work <= init_state(key, nonce, head.ctr);
    end else if (busy) begin
      work <= do_round(work, rnd[0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      rnd  <= '0;
    end else begin
      if (start) begin
        busy <= 1'b1;
        done <= 1'b0;
        rnd  <= '0;
      end else if (busy) begin
        rnd <= rnd + 1'b1;
        if (rnd == RndW'(NumRnd - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end else if (res_take) begin
        done <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/cc_out.sv =====
// output buffer: holds one finished block and sends it a word at a time
// depends on cc_pkg
`default_nettype none
module cc_out
  import cc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        res_valid,
  input  wire state_t      res,
  output logic             res_take,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [WordW-1:0] keystream_word,
  output logic [3:0]       word_index,
  output logic             last_word
);

  state_t     blk;
  logic [3:0] idx;
  logic       vld;
  logic       acc;

  assign acc            = vld && out_ready;
  // refill as the last word of the previous block leaves
  assign res_take       = res_valid && (!vld || (acc && idx == 4'd15));
  assign out_valid      = vld;
  assign keystream_word = blk[0];
  assign word_index     = idx;
  assign last_word      = (idx == 4'd15);

  always_ff @(posedge clk) begin
    if (res_take) begin
      blk <= res;
    end else if (acc) begin
      blk <= {WordW'(0), blk[15:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
      idx <= 4'd0;
    end else begin
      if (res_take) begin
        vld <= 1'b1;
        idx <= 4'd0;
      end else if (acc) begin
        idx <= idx + 4'd1;
        if (idx == 4'd15) begin
          vld <= 1'b0;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/chacha20_keystream_block.sv =====
// chacha20 keystream block top level: key/nonce registers and the three stages
// depends on cc_pkg, cc_front, cc_rounds, cc_out
//
// usage:
//   load key and nonce through the write port (cfg_write, cfg_index, cfg_data)
//   while the block is idle; index 0..3 are key word pairs, 4 is nonce words
//   0 and 1, 5 is nonce word 2 (low 32 bits). other indexes are ignored.
//   each request on the input channel carries a 32-bit block counter and
//   yields sixteen keystream words on the output channel, in order, with
//   word_index 0..15 and last_word set on the sixteenth.
// on an idle block an accepted counter passes through the queue, then the
//   20 rounds of the round engine (one column or diagonal round each), then
//   the load of the output buffer, before the first word is presented.
// the round engine sets the block rate; the output buffer drains sixteen
//   words of one block while the engine computes the next.
// the two-entry counter queue keeps taking requests while the engine works.
// when the receiver stalls, the output buffer holds its word, the engine
//   holds its finished block, and the queue fills until in_ready drops.
// reset clears all key and nonce registers to zero and empties every stage.
`default_nettype none
module chacha20_keystream_block
  import cc_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_write,
  input  wire logic [2:0]       cfg_index,
  input  wire logic [CfgW-1:0]  cfg_data,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [WordW-1:0] block_counter,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [WordW-1:0]      keystream_word,
  output logic [3:0]            word_index,
  output logic                  last_word
);

  key_t    key;
  nonce_t  nonce;
  cc_req_t head;
  logic    pop;
  logic    res_valid;
  logic    res_take;
  state_t  res;

  always_ff @(posedge clk) begin
    if (rst) begin
      key   <= '0;
      nonce <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_KEY_0_1:   key[1:0]   <= cfg_data;
        REG_KEY_2_3:   key[3:2]   <= cfg_data;
        REG_KEY_4_5:   key[5:4]   <= cfg_data;
        REG_KEY_6_7:   key[7:6]   <= cfg_data;
        REG_NONCE_0_1: nonce[1:0] <= cfg_data;
        REG_NONCE_2:   nonce[2]   <= cfg_data[WordW-1:0];
        default: ;
      endcase
    end
  end

  cc_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .block_counter (block_counter),
    .head          (head),
    .pop           (pop)
  );

  cc_rounds u_rounds (
    .clk       (clk),
    .rst       (rst),
    .key       (key),
    .nonce     (nonce),
    .head      (head),
    .pop       (pop),
    .res_valid (res_valid),
    .res       (res),
    .res_take  (res_take)
  );

  cc_out u_out (
    .clk            (clk),
    .rst            (rst),
    .res_valid      (res_valid),
    .res            (res),
    .res_take       (res_take),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .keystream_word (keystream_word),
    .word_index     (word_index),
    .last_word      (last_word)
  );

`ifndef SYNTHESIS
  // words of a block leave in order
  a_idx_step: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last_word |=>
      out_valid && word_index == $past(word_index) + 4'd1)
    else $error("word index did not advance by one");

  // a new block always starts at word zero
  a_blk_start: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && last_word |=> !out_valid || word_index == 4'd0)
    else $error("block did not start at word zero");

  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> word_index == 4'd0 && !last_word)
    else $error("output started mid-block");

  a_rst_empty: assert property (@(posedge clk)
    $past(rst) && !rst |-> !out_valid && in_ready)
    else $error("stages not empty after reset");
`endif

endmodule
`default_nettype wire
